[design/binary_to_decimal_digits_core_macros.svh]
// Assertion macros used by binary_to_decimal_digits_core.sv.
`ifndef BINARY_TO_DECIMAL_DIGITS_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BTDD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define BTDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/btdd_pkg.sv]
package btdd_pkg;

  localparam int VALUE_BITS_DEFAULT = 128;
  localparam int HALF_BITS = 64;
  localparam int DIGIT_BITS = 4;
  localparam int CHAR_BITS = 6;
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic clear;
    logic shift_bit;
    logic shift_digit;
  } cell_ctrl_t;

  function automatic int num_digits(input int bits);
    num_digits = (bits * 30103) / 100000 + 1;
  endfunction

endpackage

[design/btdd_cell.sv]
module btdd_cell (
  input  logic                                clk,
  input  btdd_pkg::cell_ctrl_t                ctrl,
  input  logic                                cin,
  input  logic [btdd_pkg::DIGIT_BITS-1:0]     din,
  output logic [btdd_pkg::DIGIT_BITS-1:0]     digit,
  output logic                                cout
);

  logic [btdd_pkg::DIGIT_BITS-1:0] adj;

  always_comb begin
    adj  = (digit >= 4'd5) ? digit + 4'd3 : digit;
    cout = adj[btdd_pkg::DIGIT_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift_bit) begin
      digit <= {adj[btdd_pkg::DIGIT_BITS-2:0], cin};
    end else if (ctrl.shift_digit) begin
      digit <= din;
    end
  end

endmodule

[design/binary_to_decimal_digits_core.sv]
// Binary to decimal digit converter.
// Pulse start while busy is low to hand in one word: value_high and
// value_low form an unsigned value, of which the low VALUE_BITS bits count.
// The value shifts, one bit a cycle, into a row of DIGITS BCD cells (39 at
// 128 bits) that each hold one digit and add three to a digit of five or
// more before shifting. The row then moves up by one digit a cycle, the top
// digit being read out; leading zeros give no output.
// Each digit appears on digit_char for one cycle with strobe high, most
// significant first; last_digit marks the final one. Zero gives one '0'.
// busy stays high from the accepting edge until the final digit is put out,
// so a new word is taken only after the last one is through, in an idle
// cycle.
// The receiver cannot stall; every strobe is one accepted digit.
// rst is synchronous and returns the block to idle, dropping any word.
`include "binary_to_decimal_digits_core_macros.svh"

module binary_to_decimal_digits_core #(
  parameter int VALUE_BITS = btdd_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [btdd_pkg::HALF_BITS-1:0]     value_high,
  input  logic [btdd_pkg::HALF_BITS-1:0]     value_low,
  output logic                               busy,
  output logic                               strobe,
  output logic [btdd_pkg::CHAR_BITS-1:0]     digit_char,
  output logic                               last_digit
);

  localparam int Digits  = btdd_pkg::num_digits(VALUE_BITS);
  localparam int BitCntW = $clog2(VALUE_BITS);
  localparam int RemW    = $clog2(Digits + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                         state;
  logic [BitCntW-1:0]                 bit_cnt;
  logic [RemW-1:0]                    rem;
  logic                               seen;
  logic [VALUE_BITS-1:0]              shreg;
  logic [2*btdd_pkg::HALF_BITS-1:0]   value_full;
  logic                               accept;
  logic                               emit_now;
  btdd_pkg::cell_ctrl_t               ctrl;
  logic [btdd_pkg::DIGIT_BITS-1:0]    dig   [Digits];
  logic [btdd_pkg::DIGIT_BITS-1:0]    din_w [Digits];
  logic                               carry [Digits+1];
  logic [btdd_pkg::DIGIT_BITS-1:0]    top;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign value_full = {value_high, value_low};
  assign top        = dig[Digits-1];
  assign emit_now   = (state == S_EMIT) && (seen || (top != '0) || (rem == RemW'(1)));

  always_comb begin
    ctrl.clear       = accept;
    ctrl.shift_bit   = (state == S_CONV);
    ctrl.shift_digit = (state == S_EMIT);
  end

  assign carry[0] = shreg[VALUE_BITS-1];
  assign din_w[0] = '0;

  for (genvar i = 0; i < Digits; i++) begin : g_cell
    if (i > 0) begin : g_din
      assign din_w[i] = dig[i-1];
    end
    btdd_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .cin   (carry[i]),
      .din   (din_w[i]),
      .digit (dig[i]),
      .cout  (carry[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      seen   <= 1'b0;
    end else begin
      strobe <= emit_now;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
            seen  <= 1'b0;
          end
        end
        S_CONV: begin
          if (bit_cnt == '0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_now) begin
            seen <= 1'b1;
          end
          if (rem == RemW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg   <= value_full[VALUE_BITS-1:0];
      bit_cnt <= BitCntW'(VALUE_BITS - 1);
      rem     <= RemW'(Digits);
    end else if (state == S_CONV) begin
      shreg   <= shreg << 1;
      bit_cnt <= bit_cnt - 1'b1;
    end else if (state == S_EMIT) begin
      rem     <= rem - 1'b1;
    end
    if (emit_now) begin
      digit_char <= btdd_pkg::ASCII_ZERO + {2'b00, top};
      last_digit <= (rem == RemW'(1));
    end
  end

  `BTDD_ASSERT_NOW(a_char_range, strobe, (digit_char >= 6'd48) && (digit_char <= 6'd57))
  `BTDD_ASSERT_NEXT(a_start_busy, accept, busy)
  `BTDD_ASSERT_NEXT(a_last_ends, strobe && last_digit, !strobe)
  `BTDD_ASSERT_NOW(a_no_overflow, state == S_CONV, !carry[Digits])
  `BTDD_ASSERT_NOW(a_quiet_conv, state == S_CONV, !strobe)

endmodule

[bench/digit_checker.sv]
`timescale 1ns / 1ps

module digit_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [btdd_pkg::HALF_BITS-1:0] value_high,
  input  logic [btdd_pkg::HALF_BITS-1:0] value_low,
  input  logic                           strobe,
  input  logic [btdd_pkg::CHAR_BITS-1:0] digit_char,
  input  logic                           last_digit,
  output int                             errors,
  output int                             pending,
  output int                             digits_seen
);

  localparam int VALUE_BITS = btdd_pkg::VALUE_BITS_DEFAULT;
  localparam int VALUE_W = 2 * btdd_pkg::HALF_BITS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [btdd_pkg::CHAR_BITS-1:0] ch;
    logic                           last;
  } digit_t;

  digit_t expected_digits[$];

  function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] mask;
    logic [3:0]         low_first[$];
    digit_t             d;
    mask = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);
    rest = value & mask;
    do begin
      low_first.push_back(4'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    for (int i = low_first.size() - 1; i >= 0; i--) begin
      d.ch = btdd_pkg::ASCII_ZERO + {2'b00, low_first[i]};
      d.last = (i == 0);
      expected_digits.push_back(d);
    end
  endfunction

  always @(posedge clk) begin
    digit_t want;
    if (rst) begin
      expected_digits.delete();
    end else begin
      if (strobe) begin
        digits_seen++;
        if (expected_digits.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected digit char=%0d last=%b", $realtime, digit_char,
                     last_digit);
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.ch || last_digit !== want.last) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: digit mismatch: expected char=%0d last=%b, got char=%0d last=%b",
                       $realtime, want.ch, want.last, digit_char, last_digit);
          end
        end
      end
      if (start && !busy)
        queue_decimal_digits({value_high, value_low});
    end
    pending = expected_digits.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS = 160;
  localparam int DRAIN_CYCLES = 200;
  localparam int VALUE_W = 2 * btdd_pkg::HALF_BITS;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic [btdd_pkg::HALF_BITS-1:0] value_high = '0;
  logic [btdd_pkg::HALF_BITS-1:0] value_low = '0;
  logic                           busy;
  logic                           strobe;
  logic [btdd_pkg::CHAR_BITS-1:0] digit_char;
  logic                           last_digit;

  int errors;
  int pending;
  int digits_seen;
  int words_sent = 0;
  int quiet_cycles = 0;

  binary_to_decimal_digits_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .value_high (value_high),
    .value_low  (value_low),
    .busy       (busy),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  digit_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value_high  (value_high),
    .value_low   (value_low),
    .strobe      (strobe),
    .digit_char  (digit_char),
    .last_digit  (last_digit),
    .errors      (errors),
    .pending     (pending),
    .digits_seen (digits_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [VALUE_W-1:0] value, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    {value_high, value_low} <= value;
    @(posedge clk);
    while (!(start && !busy)) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0] pow10;
    logic [VALUE_W-1:0] value;
    int                 idle_plan[3];
    idle_plan = '{0, 67, 27};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_word(128'd0, 0);
    send_word(128'd1, 0);
    send_word(128'd9, 0);
    send_word(128'd10, 0);
    pow10 = 1;
    for (int k = 1; k <= 38; k++) begin
      pow10 = pow10 * 10;
      if (k inside {2, 19, 20, 38}) begin
        send_word(pow10 - 1, 0);
        send_word(pow10, 0);
      end
    end
    send_word({64'h0, {64{1'b1}}}, 0);
    send_word({64'h1, 64'h0}, 0);
    send_word({128{1'b1}}, 0);
    send_word({{64{1'b1}}, 64'h0}, 0);
    send_word({64{2'b10}}, 0);
    send_word({64{2'b01}}, 0);

    for (int p = 0; p < 3; p++) begin
      // hold off until every digit of the previous phase is out
      start <= 1'b0;
      do @(negedge clk); while (pending != 0);
      repeat (PHASE_WORDS) begin
        case ($urandom_range(0, 3))
          0: value = {$urandom, $urandom, $urandom, $urandom};
          1: value = {$urandom, $urandom, $urandom, $urandom} >> (128 - $urandom_range(1, 128));
          2: begin
            pow10 = 1;
            repeat ($urandom_range(0, 38)) pow10 = pow10 * 10;
            value = pow10 + $urandom_range(0, 4) - 2;
          end
          default: value = $urandom_range(0, 1000);
        endcase
        send_word(value, idle_plan[p]);
      end
    end

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d words (zero, powers of ten and their neighbors, all-ones, random",
             words_sent);
    $display("widths) under three sender pacings; %0d digits checked.", digits_seen);
    if (errors == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/btdd_pkg.sv
design/btdd_cell.sv
design/binary_to_decimal_digits_core.sv
bench/digit_checker.sv
bench/tb.sv
